@@ hdl/thc_pkg.sv @@
// ----------------------------------------------------------------------------
// Thermocouple averager package
// Widths, unit codes and the unit conversion offsets shared by the block.
// ----------------------------------------------------------------------------
package thc_pkg;

    localparam int SAMPLE_W   = 14;
    localparam int SAMPLE_LSB = 18;
    localparam int FRAME_W    = 32;
    localparam int SUM_W      = 17;
    localparam int OUT_W      = 20;
    localparam int NUM_CELLS  = 4;

    localparam logic signed [OUT_W:0] F_OFFSET = 21'sd3200;
    localparam logic signed [OUT_W:0] K_OFFSET = 21'sd27315;

    typedef enum logic [1:0] {
        UNIT_CELSIUS    = 2'd0,
        UNIT_FAHRENHEIT = 2'd1,
        UNIT_KELVIN     = 2'd2
    } t_unit;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic signed [OUT_W-1:0]    t_result;

endpackage

@@ hdl/thc_cell.sv @@
// ----------------------------------------------------------------------------
// Thermocouple averager history cell
// Holds one past sample, passes it on to the next cell when a new sample
// enters, and adds its sample to the running sum that flows along the chain.
// ----------------------------------------------------------------------------
module thc_cell
    import thc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_shift,
    input  t_sample i_sample,
    output t_sample o_sample,
    input  t_sum    i_sum,
    output t_sum    o_sum
);

    t_sample r_sample;
    t_sample n_sample;

    always_comb begin
        n_sample = r_sample;
        if (i_shift) begin
            n_sample = i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else begin
            r_sample <= n_sample;
        end
    end

    assign o_sample = r_sample;
    assign o_sum    = i_sum + SUM_W'(r_sample);

endmodule

@@ hdl/thc_convert.sv @@
// ----------------------------------------------------------------------------
// Thermocouple averager unit conversion
// Turns the five-sample sum in quarter degrees Celsius into hundredths of a
// degree in Celsius, Fahrenheit or Kelvin.
// ----------------------------------------------------------------------------
module thc_convert
    import thc_pkg::*;
(
    input  t_sum       i_sum,
    input  logic [1:0] i_unit,
    output t_result    o_result
);

    logic signed [OUT_W:0] sum_ext;
    logic signed [OUT_W:0] times5;
    logic signed [OUT_W:0] times9;
    logic signed [OUT_W:0] result;

    assign sum_ext = (OUT_W+1)'(i_sum);
    assign times5  = (sum_ext <<< 2) + sum_ext;
    assign times9  = (sum_ext <<< 3) + sum_ext;

    always_comb begin
        case (i_unit)
            UNIT_FAHRENHEIT: result = times9 + F_OFFSET;
            UNIT_KELVIN:     result = times5 + K_OFFSET;
            default:         result = times5;
        endcase
    end

    assign o_result = result[OUT_W-1:0];

endmodule

@@ hdl/thermocouple_avg_unit_convert.sv @@
// ----------------------------------------------------------------------------
// Thermocouple five-sample average with unit conversion
// Each input transaction carries a converter frame whose bits 31..18 are a
// signed temperature in quarter degrees Celsius. The block returns one
// result transaction per input: the average of that sample and the four
// before it, in hundredths of a degree of the selected unit (unit code 3
// reads as Celsius). After reset the history reads as zero samples. The
// history lives in a row of four cells that shift on every accepted
// transaction while the sum ripples through them; the result is written into
// an output register on acceptance, and a new transaction is taken every
// cycle as long as that register is empty or being emptied.
// ----------------------------------------------------------------------------
module thermocouple_avg_unit_convert
    import thc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [FRAME_W-1:0] i_raw_frame,
    input  logic [1:0]         i_unit,
    output logic               o_valid,
    input  logic               i_stall,
    output t_result            o_avg_temp_centi
);

    logic    accept;
    t_sample new_sample;
    t_sample cell_data [NUM_CELLS+1];
    t_sum    cell_sum  [NUM_CELLS+1];
    t_result result;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_stall    = r_valid & i_stall;
    assign accept     = i_valid & ~o_stall;
    assign new_sample = i_raw_frame[SAMPLE_LSB +: SAMPLE_W];

    assign cell_data[0] = new_sample;
    assign cell_sum[0]  = SUM_W'(new_sample);

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        thc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (accept),
            .i_sample (cell_data[g]),
            .o_sample (cell_data[g+1]),
            .i_sum    (cell_sum[g]),
            .o_sum    (cell_sum[g+1])
        );
    end

    thc_convert u_convert (
        .i_sum    (cell_sum[NUM_CELLS]),
        .i_unit   (i_unit),
        .o_result (result)
    );

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= result;
        end
    end

    assign o_valid          = r_valid;
    assign o_avg_temp_centi = r_result;

endmodule

@@ sim/thermocouple_avg_unit_convert_tb.sv @@
// ----------------------------------------------------------------------------
// Testbench for the thermocouple five-sample averager
// A short table of directed frames covers both temperature extremes, every
// unit code and the zero history after reset. Random frames follow under
// four idling patterns. Each accepted input transaction is folded into a
// local copy of the sample history, and each output transaction is compared
// with the oldest pending average.
// ----------------------------------------------------------------------------
module thermocouple_avg_unit_convert_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import thc_pkg::*;

    localparam logic [1:0] UNIT_SPARE   = 2'd3;
    localparam int         RING_LEN     = 5;
    localparam int         RESET_CYCLES = 4;
    localparam int         PHASE_ITEMS  = 138;
    localparam int         DRAIN_CYCLES = 20;
    localparam int         LIMIT_CYCLES = 200000;

    typedef struct {
        logic [FRAME_W-1:0] frame;
        logic [1:0]         unit;
        bit                 typed;
        t_result            avg;
    } t_frame_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [FRAME_W-1:0] i_raw_frame = '0;
    logic [1:0]         i_unit = UNIT_CELSIUS;
    logic               o_valid;
    logic               i_stall = 1'b0;
    t_result            o_avg_temp_centi;

    bit                 row_typed = 1'b0;
    t_result            row_avg = '0;
    int unsigned        send_idle_pct = 0;
    int unsigned        recv_stall_pct = 0;
    int unsigned        errors = 0;
    int unsigned        cycles = 0;

    t_sample            ring_q4 [RING_LEN] = '{default: '0};
    int unsigned        ring_slot = 0;
    t_result            pending_avg_q [$];
    t_frame_row         frame_rows [$];

    thermocouple_avg_unit_convert i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_raw_frame      (i_raw_frame),
        .i_unit           (i_unit),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_avg_temp_centi (o_avg_temp_centi)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_result fold_sample(input logic [FRAME_W-1:0] frame,
                                            input logic [1:0] unit);
        int          sum_q4;
        int          centi;
        ring_q4[ring_slot] = t_sample'(frame[SAMPLE_LSB +: SAMPLE_W]);
        ring_slot = (ring_slot == RING_LEN - 1) ? 0 : ring_slot + 1;
        sum_q4 = 0;
        for (int k = 0; k < RING_LEN; k++) begin
            sum_q4 += ring_q4[k];
        end
        case (unit)
            UNIT_FAHRENHEIT: centi = 9 * sum_q4 + int'(F_OFFSET);
            UNIT_KELVIN:     centi = 5 * sum_q4 + int'(K_OFFSET);
            default:         centi = 5 * sum_q4;
        endcase
        return t_result'(centi);
    endfunction

    task automatic add_row(input logic [FRAME_W-1:0] frame, input logic [1:0] unit,
                           input bit typed, input int avg);
        t_frame_row row;
        row.frame = frame;
        row.unit  = unit;
        row.typed = typed;
        row.avg   = t_result'(avg);
        frame_rows.push_back(row);
    endtask

    task automatic send_frame(input logic [FRAME_W-1:0] frame, input logic [1:0] unit,
                              input bit typed, input t_result avg);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_raw_frame <= frame;
        i_unit      <= unit;
        row_typed   <= typed;
        row_avg     <= avg;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_avg_q.size() != 0) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_result predicted;
        t_result wanted;
        if (i_rst_n && i_valid && !o_stall) begin
            predicted = fold_sample(i_raw_frame, i_unit);
            pending_avg_q.push_back(row_typed ? row_avg : predicted);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_avg_q.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual %0d",
                         $time, o_avg_temp_centi);
                errors++;
            end else begin
                wanted = pending_avg_q.pop_front();
                if (o_avg_temp_centi !== wanted) begin
                    $display("%0t: avg_temp_centi mismatch, expected %0d, actual %0d",
                             $time, wanted, o_avg_temp_centi);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d results pending", $time, pending_avg_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        logic [FRAME_W-1:0] frame;
        logic [1:0]         unit;

        add_row(32'h0000_0000, UNIT_CELSIUS,    1'b1, 0);
        add_row(32'h0003_FFFF, UNIT_FAHRENHEIT, 1'b1, 3200);
        add_row(32'h0000_0000, UNIT_KELVIN,     1'b1, 27315);
        add_row(32'h0000_0000, UNIT_SPARE,      1'b1, 0);
        add_row(32'h7FFC_0000, UNIT_CELSIUS,    1'b1, 40955);
        add_row(32'h7FFF_FFFF, UNIT_CELSIUS,    1'b0, 0);
        add_row(32'h7FFC_0000, UNIT_KELVIN,     1'b0, 0);
        add_row(32'h7FFC_1234, UNIT_SPARE,      1'b0, 0);
        add_row(32'h7FFF_FFFF, UNIT_FAHRENHEIT, 1'b1, 371795);
        add_row(32'h8000_0000, UNIT_CELSIUS,    1'b0, 0);
        add_row(32'h8003_FFFF, UNIT_FAHRENHEIT, 1'b0, 0);
        add_row(32'h8000_0000, UNIT_KELVIN,     1'b0, 0);
        add_row(32'h8000_0000, UNIT_SPARE,      1'b0, 0);
        add_row(32'h8000_0000, UNIT_FAHRENHEIT, 1'b1, -365440);
        add_row(32'h8003_FFFF, UNIT_KELVIN,     1'b1, -177485);
        add_row(32'h8000_0000, UNIT_CELSIUS,    1'b1, -204800);
        add_row(32'hFFFF_FFFF, UNIT_SPARE,      1'b0, 0);
        add_row(32'h0004_0000, UNIT_CELSIUS,    1'b0, 0);
        add_row(32'h2000_0000, UNIT_FAHRENHEIT, 1'b0, 0);
        add_row(32'h5555_AAAA, UNIT_KELVIN,     1'b0, 0);
        add_row(32'hAAAA_5555, UNIT_CELSIUS,    1'b0, 0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (frame_rows[r]) begin
            send_frame(frame_rows[r].frame, frame_rows[r].unit,
                       frame_rows[r].typed, frame_rows[r].avg);
        end
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            repeat (PHASE_ITEMS) begin
                frame = $urandom;
                if ($urandom_range(0, 4) == 0) begin
                    case ($urandom_range(0, 3))
                        0:       frame[31:18] = 14'h1FFF;
                        1:       frame[31:18] = 14'h2000;
                        2:       frame[31:18] = 14'h3FFF;
                        default: frame[31:18] = 14'h0000;
                    endcase
                end
                unit = 2'($urandom_range(0, 3));
                send_frame(frame, unit, 1'b0, '0);
            end
            if (ph == 1) wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
